// ===== sv/pl_pkg.sv =====
// shared types and constants for the positional list engine
package pl_pkg;

    localparam int OPCODE_W   = 3;
    localparam int POSITION_W = 7;
    localparam int HANDLE_PW  = 16;
    localparam int COUNT_PW   = 7;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INS_HEAD = 3'd0,
        OP_INS_TAIL = 3'd1,
        OP_INS_AT   = 3'd2,
        OP_REM_HEAD = 3'd3,
        OP_REM_TAIL = 3'd4,
        OP_REM_AT   = 3'd5,
        OP_READ_AT  = 3'd6,
        OP_READ_HEAD = 3'd7
    } pl_op_t;

    // shift command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic rem;
    } pl_shift_t;

endpackage

// ===== sv/pl_in_if.sv =====
// request channel: one list operation per word
interface pl_in_if;
    import pl_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [OPCODE_W-1:0]   opcode;
    logic [POSITION_W-1:0] position;
    logic [HANDLE_PW-1:0]  handle_in;

    modport source (output valid, output opcode, output position, output handle_in,
                    input ready);
    modport sink   (input valid, input opcode, input position, input handle_in,
                    output ready);
endinterface

// ===== sv/pl_out_if.sv =====
// response channel: one result per word
interface pl_out_if;
    import pl_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 ok;
    logic [HANDLE_PW-1:0] handle_out;
    logic [COUNT_PW-1:0]  entry_count;

    modport source (output valid, output ok, output handle_out, output entry_count,
                    input ready);
    modport sink   (input valid, input ok, input handle_out, input entry_count,
                    output ready);
endinterface

// ===== sv/pl_cell.sv =====
// one list slot: holds a handle and shifts with its neighbors
module pl_cell #(
    parameter int HANDLE_W = 16,
    parameter int IDX_W    = 6,
    parameter int INDEX    = 0
) (
    input  logic                clk,
    input  pl_pkg::pl_shift_t   shift,
    input  logic [IDX_W-1:0]    pos,
    input  logic [HANDLE_W-1:0] handle,
    input  logic [HANDLE_W-1:0] left,
    input  logic [HANDLE_W-1:0] right,
    output logic [HANDLE_W-1:0] data,
    output logic [HANDLE_W-1:0] rd
);
    import pl_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [HANDLE_W-1:0] data_reg;
    logic [HANDLE_W-1:0] data_next;

    // insert opens a gap at pos, remove closes it
    always_comb
    begin
        data_next = data_reg;
        if (shift.ins)
        begin
            if (MY_IDX == pos)
                data_next = handle;
            else if (MY_IDX > pos)
                data_next = left;
        end
        else if (shift.rem)
        begin
            if (MY_IDX >= pos)
                data_next = right;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    // drive the read bus only when selected
    assign data = data_reg;
    assign rd   = (MY_IDX == pos) ? data_reg : '0;

endmodule

// ===== sv/positional_list_engine.sv =====
// top level of the positional list engine
// Ordered list of handles held in a row of DEPTH cells; position 0 is the head.
// Every operation (insert or remove at head, tail or any position, read at head or
// any position) acts on all cells in parallel: they shift on the accepting edge, and
// the result word is registered and offered on the next cycle. A new word is accepted
// every cycle while the result register is empty or being drained, so the sustained
// rate is one operation per clock. Refused operations (position out of range,
// empty list, full list) return ok low, a zero handle and leave the list as is.
module positional_list_engine #(
    parameter int DEPTH    = 64,
    parameter int HANDLE_W = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    pl_in_if.sink    req,
    pl_out_if.source rsp
);
    import pl_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POSITION_W) ? CNT_W : POSITION_W;
    localparam int EXT_W = (HANDLE_W > HANDLE_PW) ? HANDLE_W : HANDLE_PW;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic                 out_valid_reg;
    logic                 ok_reg;
    logic [HANDLE_PW-1:0] hout_reg;
    logic [COUNT_PW-1:0]  cnt_out_reg;

    logic                 accept;
    logic                 is_ins;
    logic                 is_rem;
    logic                 op_ok;
    logic [CMP_W-1:0]     cnt_ext;
    logic [CMP_W-1:0]     pos_ext;
    logic [CMP_W-1:0]     tgt;
    logic [CMP_W-1:0]     cnt_new_ext;
    logic [EXT_W-1:0]     hin_ext;
    logic [EXT_W-1:0]     rd_ext;
    logic [HANDLE_W-1:0]  rd_bus;
    pl_shift_t            shift;

    logic [HANDLE_W-1:0]  cell_data [DEPTH];
    logic [HANDLE_W-1:0]  cell_rd   [DEPTH];

    assign accept  = req.valid && req.ready;
    assign cnt_ext = CMP_W'(cnt_reg);
    assign pos_ext = CMP_W'(req.position);
    assign hin_ext = EXT_W'(req.handle_in);

    // decode target position and legality
    always_comb
    begin
        is_ins = 1'b0;
        tgt    = '0;
        case (pl_op_t'(req.opcode))
            OP_INS_HEAD:
            begin
                is_ins = 1'b1;
                tgt    = '0;
            end
            OP_INS_TAIL:
            begin
                is_ins = 1'b1;
                tgt    = cnt_ext;
            end
            OP_INS_AT:
            begin
                is_ins = 1'b1;
                tgt    = pos_ext;
            end
            OP_REM_HEAD:  tgt = '0;
            OP_REM_TAIL:  tgt = cnt_ext - CMP_W'(1);
            OP_REM_AT:    tgt = pos_ext;
            OP_READ_AT:   tgt = pos_ext;
            OP_READ_HEAD: tgt = '0;
            default:      tgt = '0;
        endcase
    end

    assign is_rem = (pl_op_t'(req.opcode) == OP_REM_HEAD) ||
                    (pl_op_t'(req.opcode) == OP_REM_TAIL) ||
                    (pl_op_t'(req.opcode) == OP_REM_AT);

    assign op_ok = is_ins ? ((cnt_ext != DEPTH_C) && (tgt <= cnt_ext))
                          : ((cnt_ext != '0) && (tgt < cnt_ext));

    assign shift.ins = accept && op_ok && is_ins;
    assign shift.rem = accept && op_ok && is_rem;

    // row of cells
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [HANDLE_W-1:0] left_d;
        logic [HANDLE_W-1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_d = cell_data[i];
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[i+1];
        end

        pl_cell #(
            .HANDLE_W (HANDLE_W),
            .IDX_W    (IDX_W),
            .INDEX    (i)
        ) u_cell (
            .clk    (clk),
            .shift  (shift),
            .pos    (tgt[IDX_W-1:0]),
            .handle (hin_ext[HANDLE_W-1:0]),
            .left   (left_d),
            .right  (right_d),
            .data   (cell_data[i]),
            .rd     (cell_rd[i])
        );
    end

    // combine the selected cell onto the read bus
    always_comb
    begin
        rd_bus = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rd_bus = rd_bus | cell_rd[i];
        end
    end

    assign rd_ext = EXT_W'(rd_bus);

    // count update
    always_comb
    begin
        cnt_next = cnt_reg;
        if (shift.ins)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (shift.rem)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    assign cnt_new_ext = CMP_W'(cnt_next);

    // count and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ok_reg      <= op_ok;
            hout_reg    <= (op_ok && !is_ins) ? rd_ext[HANDLE_PW-1:0] : '0;
            cnt_out_reg <= cnt_new_ext[COUNT_PW-1:0];
        end
    end

    assign req.ready       = !out_valid_reg || rsp.ready;
    assign rsp.valid       = out_valid_reg;
    assign rsp.ok          = ok_reg;
    assign rsp.handle_out  = hout_reg;
    assign rsp.entry_count = cnt_out_reg;

endmodule

// ===== verif/tb_positional_list_engine.sv =====
// self-checking testbench for the positional list engine: directed table plus random traffic
`timescale 1ns / 1ps

module tb_positional_list_engine;
    import pl_pkg::*;

    localparam int LIST_DEPTH   = 64;
    localparam int RANDOM_WORDS = 1380;
    localparam int QUIET_WORDS  = 150;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 150;
    localparam int HOLD_AFTER   = 400;
    localparam int REPORT_LIMIT = 10;

    // one result word as the engine reports it
    typedef struct packed {
        logic                 ok;
        logic [HANDLE_PW-1:0] handle;
        logic [COUNT_PW-1:0]  count;
    } list_result_t;

    // one directed request word, with an optional hand-typed result
    typedef struct {
        pl_op_t                op;
        logic [POSITION_W-1:0] pos;
        logic [HANDLE_PW-1:0]  handle;
        bit                    typed;
        list_result_t          want;
    } list_row_t;

    // random traffic flavors
    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN,
        MIX_READ
    } mix_t;

    logic clk = 1'b0;
    logic rst_n;

    pl_in_if  req_if ();
    pl_out_if rsp_if ();

    positional_list_engine #(
        .DEPTH    (LIST_DEPTH),
        .HANDLE_W (HANDLE_PW)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // shadow copy of the list
    logic [HANDLE_PW-1:0] shadow_cells [LIST_DEPTH];
    int unsigned          shadow_len = 0;

    list_result_t pending_results [$];
    list_row_t    directed_rows [$];
    int           fail_count  = 0;
    int           words_sent  = 0;
    bit           tail_quiet  = 1'b0;
    bit           hold_long   = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // apply one operation to the shadow list and return the result it gives
    function automatic list_result_t predict_list_op(pl_op_t op, int unsigned pos,
                                                     logic [HANDLE_PW-1:0] h);
        list_result_t r;
        int unsigned  at;
        int unsigned  i;
        r  = '0;
        at = 0;
        case (op)
            OP_INS_HEAD, OP_INS_TAIL, OP_INS_AT:
            begin
                if (op == OP_INS_TAIL)
                    at = shadow_len;
                else if (op == OP_INS_AT)
                    at = pos;
                if (shadow_len < LIST_DEPTH && at <= shadow_len)
                begin
                    for (i = shadow_len; i > at; i--)
                        shadow_cells[i] = shadow_cells[i-1];
                    shadow_cells[at] = h;
                    shadow_len++;
                    r.ok = 1'b1;
                end
            end
            OP_REM_HEAD, OP_REM_TAIL, OP_REM_AT:
            begin
                if (op == OP_REM_TAIL)
                    at = (shadow_len > 0) ? shadow_len - 1 : 0;
                else if (op == OP_REM_AT)
                    at = pos;
                if (shadow_len > 0 && at < shadow_len)
                begin
                    r.handle = shadow_cells[at];
                    for (i = at; i + 1 < shadow_len; i++)
                        shadow_cells[i] = shadow_cells[i+1];
                    shadow_len--;
                    r.ok = 1'b1;
                end
            end
            OP_READ_AT:
            begin
                if (pos < shadow_len)
                begin
                    r.handle = shadow_cells[pos];
                    r.ok     = 1'b1;
                end
            end
            default:
            begin
                if (shadow_len > 0)
                begin
                    r.handle = shadow_cells[0];
                    r.ok     = 1'b1;
                end
            end
        endcase
        r.count = shadow_len[COUNT_PW-1:0];
        return r;
    endfunction

    function automatic void add_row(pl_op_t op, int unsigned pos, logic [HANDLE_PW-1:0] h,
                                    bit typed, logic ok, logic [HANDLE_PW-1:0] hout,
                                    int unsigned cnt);
        list_row_t row;
        row.op     = op;
        row.pos    = pos[POSITION_W-1:0];
        row.handle = h;
        row.typed  = typed;
        row.want   = '{ok, hout, cnt[COUNT_PW-1:0]};
        directed_rows.push_back(row);
    endfunction

    // offer one request word, wait for the handshake, then log its result
    task automatic send_word(pl_op_t op, logic [POSITION_W-1:0] pos,
                             logic [HANDLE_PW-1:0] h, bit typed, list_result_t want);
        list_result_t predicted;
        @(negedge clk);
        if (!tail_quiet && $urandom_range(0, 4) == 0)
        begin
            // idle burst with junk on the payload
            req_if.valid     <= 1'b0;
            req_if.opcode    <= OPCODE_W'($urandom_range(0, 7));
            req_if.position  <= POSITION_W'($urandom_range(0, 127));
            req_if.handle_in <= HANDLE_PW'($urandom_range(0, 65535));
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        req_if.valid     <= 1'b1;
        req_if.opcode    <= op;
        req_if.position  <= pos;
        req_if.handle_in <= h;
        do
            @(posedge clk);
        while (req_if.ready !== 1'b1);
        predicted = predict_list_op(op, 32'(pos), h);
        pending_results.push_back(typed ? want : predicted);
        words_sent++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        list_result_t got;
        list_result_t want;
        if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
        begin
            got = '{rsp_if.ok, rsp_if.handle_out, rsp_if.entry_count};
            if (pending_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("unexpected result word: ok=%0b handle=%h count=%0d",
                             got.ok, got.handle, got.count);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.ok !== want.ok || got.handle !== want.handle
                    || got.count !== want.count)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display({"mismatch: exp ok=%0b handle=%h count=%0d, ",
                                  "got ok=%0b handle=%h count=%0d"},
                                 want.ok, want.handle, want.count,
                                 got.ok, got.handle, got.count);
                end
            end
        end
    end

    // receiver: random stall bursts, long hold on request, none at the end
    initial
    begin
        int stall_left;
        stall_left   = 0;
        rsp_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_long)
                rsp_if.ready <= 1'b0;
            else if (tail_quiet)
                rsp_if.ready <= 1'b1;
            else if (stall_left > 0)
            begin
                rsp_if.ready <= 1'b0;
                stall_left--;
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 6) - 1;
                rsp_if.ready <= 1'b0;
            end
            else
                rsp_if.ready <= 1'b1;
        end
    end

    // backpressure: hold the output for a long stretch so the engine stalls its input
    initial
    begin
        wait (words_sent >= HOLD_AFTER);
        @(posedge clk);
        hold_long = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_long = 1'b0;
    end

    // watchdog
    initial
    begin
        #4_000_000;
        $display("positional_list_engine verification failed");
        $finish;
    end

    // main stimulus
    initial
    begin
        pl_op_t                op;
        logic [POSITION_W-1:0] pos;
        logic [HANDLE_PW-1:0]  h;
        mix_t                  mix;
        int                    mix_left;
        int                    roll;
        int                    n;

        rst_n            = 1'b0;
        req_if.valid     = 1'b0;
        req_if.opcode    = '0;
        req_if.position  = '0;
        req_if.handle_in = '0;

        // empty list refusals, out of range inserts, then a small list worked over
        add_row(OP_READ_HEAD, 0,   16'h0000, 1'b1, 1'b0, 16'h0000, 0);
        add_row(OP_REM_HEAD,  0,   16'h0000, 1'b1, 1'b0, 16'h0000, 0);
        add_row(OP_REM_TAIL,  0,   16'h0000, 1'b1, 1'b0, 16'h0000, 0);
        add_row(OP_REM_AT,    0,   16'h0000, 1'b1, 1'b0, 16'h0000, 0);
        add_row(OP_READ_AT,   127, 16'h0000, 1'b1, 1'b0, 16'h0000, 0);
        add_row(OP_INS_AT,    1,   16'h1111, 1'b1, 1'b0, 16'h0000, 0);
        add_row(OP_INS_AT,    127, 16'h2222, 1'b1, 1'b0, 16'h0000, 0);
        add_row(OP_INS_HEAD,  127, 16'hFFFF, 1'b1, 1'b1, 16'h0000, 1);
        add_row(OP_INS_TAIL,  0,   16'h0000, 1'b1, 1'b1, 16'h0000, 2);
        add_row(OP_INS_AT,    2,   16'h1234, 1'b0, 1'b0, 16'h0000, 0);
        add_row(OP_INS_AT,    1,   16'hA5A5, 1'b0, 1'b0, 16'h0000, 0);
        add_row(OP_INS_AT,    0,   16'h5A5A, 1'b0, 1'b0, 16'h0000, 0);
        add_row(OP_READ_AT,   2,   16'h0000, 1'b0, 1'b0, 16'h0000, 0);
        add_row(OP_READ_HEAD, 99,  16'h7777, 1'b0, 1'b0, 16'h0000, 0);
        add_row(OP_READ_AT,   5,   16'h0000, 1'b1, 1'b0, 16'h0000, 5);
        add_row(OP_REM_AT,    5,   16'h0000, 1'b1, 1'b0, 16'h0000, 5);
        add_row(OP_INS_AT,    6,   16'hBEEF, 1'b1, 1'b0, 16'h0000, 5);
        add_row(OP_REM_AT,    127, 16'h0000, 1'b1, 1'b0, 16'h0000, 5);
        add_row(OP_REM_AT,    2,   16'h0000, 1'b0, 1'b0, 16'h0000, 0);
        add_row(OP_REM_TAIL,  127, 16'h0000, 1'b0, 1'b0, 16'h0000, 0);
        add_row(OP_REM_HEAD,  64,  16'h0000, 1'b0, 1'b0, 16'h0000, 0);
        add_row(OP_READ_AT,   0,   16'h0000, 1'b0, 1'b0, 16'h0000, 0);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            send_word(directed_rows[i].op, directed_rows[i].pos, directed_rows[i].handle,
                      directed_rows[i].typed, directed_rows[i].want);

        // random traffic in flavored runs; the fill runs push the list to full
        mix      = MIX_FILL;
        mix_left = 100;
        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            if (mix_left == 0)
            begin
                mix      = mix_t'($urandom_range(0, 3));
                mix_left = $urandom_range(20, 120);
            end
            mix_left--;
            tail_quiet = (n >= RANDOM_WORDS - QUIET_WORDS);

            // operation
            roll = $urandom_range(0, 99);
            case (mix)
                MIX_FILL:
                    op = (roll < 85) ? pl_op_t'($urandom_range(0, 2))
                                     : pl_op_t'($urandom_range(3, 7));
                MIX_DRAIN:
                    op = (roll < 85) ? pl_op_t'($urandom_range(3, 5))
                                     : pl_op_t'($urandom_range(0, 7));
                MIX_READ:
                    op = (roll < 40) ? OP_READ_AT
                       : (roll < 60) ? OP_READ_HEAD
                                     : pl_op_t'($urandom_range(0, 7));
                default:
                    op = pl_op_t'($urandom_range(0, 7));
            endcase

            // position, mostly legal, with boundaries and out of range mixed in
            roll = $urandom_range(0, 99);
            if (roll < 60)
                pos = POSITION_W'($urandom_range(0, shadow_len));
            else if (roll < 70)
                pos = '0;
            else if (roll < 80)
                pos = POSITION_W'(shadow_len);
            else if (roll < 88)
                pos = POSITION_W'((shadow_len > 0) ? shadow_len - 1 : 0);
            else
                pos = POSITION_W'($urandom_range(0, 127));

            // handle
            roll = $urandom_range(0, 99);
            if (roll < 5)
                h = '0;
            else if (roll < 10)
                h = '1;
            else
                h = HANDLE_PW'($urandom_range(0, 65535));

            send_word(op, pos, h, 1'b0, '0);
        end

        @(negedge clk);
        req_if.valid <= 1'b0;

        // drain, then give the engine time to show any stray word
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending_results.size() == 0)
            $display("positional_list_engine verification clean");
        else
            $display("positional_list_engine verification failed");
        $finish;
    end

endmodule
